/* hw/rtl/utf8vs_pkg.sv */
// Shared types and byte constants for the UTF-8 validating sanitizer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package utf8vs_pkg;

    // Byte codes the sanitizer recognizes or produces.
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_DEL      = 8'h7F;
    localparam logic [7:0] LEAD2_LO    = 8'hC2;
    localparam logic [7:0] LEAD2_HI    = 8'hDF;
    localparam logic [7:0] LEAD3_LO    = 8'hE0;
    localparam logic [7:0] LEAD3_HI    = 8'hEF;
    localparam logic [7:0] LEAD4_LO    = 8'hF0;
    localparam logic [7:0] LEAD4_HI    = 8'hF4;
    localparam logic [7:0] LEAD_SURR   = 8'hED;
    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_CODE   = 8'h80;
    localparam logic [7:0] E0_MIN      = 8'hA0;
    localparam logic [7:0] ED_MAX      = 8'h9F;
    localparam logic [7:0] F0_MIN      = 8'h90;
    localparam logic [7:0] F4_MAX      = 8'h8F;
    localparam logic [7:0] C1_MAX      = 8'h9F;

    // Results one input byte can cause, and the output queue geometry.
    localparam int MAX_RESULTS = 4;
    localparam int Q_DEPTH     = 8;
    localparam int Q_AW        = $clog2(Q_DEPTH);

    typedef struct packed {
        logic [7:0] byte_in;
        logic       text_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       run_last;
        logic       replaced;
    } t_out_item;

    // Result group produced by the decoder for one accepted byte.
    typedef struct packed {
        logic [2:0]                        num;
        t_out_item [MAX_RESULTS-1:0]       items;
    } t_dec_result;

endpackage

/* hw/rtl/utf8vs_decode.sv */
// Sequence decoder: holds the pending UTF-8 bytes and turns one input byte
// into zero to four result items. Depends on utf8vs_pkg.
`timescale 1ns / 1ps

module utf8vs_decode import utf8vs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  t_in_item    i_item,
    output t_dec_result o_result
);

    typedef struct packed {
        logic       emit;
        logic [7:0] value;
        logic       rep;
        logic       hold;
        logic [2:0] need;
    } t_fresh;

    // Handling of a byte when nothing is pending.
    function automatic t_fresh fresh(input logic [7:0] b, input logic last);
        t_fresh f;
        f = '{emit: 1'b1, value: CH_DOT, rep: 1'b1, hold: 1'b0, need: 3'd0};
        if (b == CH_NEWLINE) begin
            f.value = CH_NEWLINE;
            f.rep   = 1'b0;
        end else if (b == CH_TAB) begin
            f.value = CH_SPACE;
        end else if (b < CH_SPACE || b == CH_DEL) begin
            f.value = CH_DOT;
        end else if (b < CONT_CODE) begin
            f.value = b;
            f.rep   = 1'b0;
        end else begin
            if (b >= LEAD2_LO && b <= LEAD2_HI) begin
                f.need = 3'd2;
            end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
                f.need = 3'd3;
            end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
                f.need = 3'd4;
            end
            if (f.need != 3'd0 && !last) begin
                f.emit = 1'b0;
                f.hold = 1'b1;
            end
        end
        return f;
    endfunction

    function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
        logic ok;
        ok = 1'b1;
        if (lead == LEAD3_LO && b < E0_MIN) ok = 1'b0;
        if (lead == LEAD_SURR && b > ED_MAX) ok = 1'b0;
        if (lead == LEAD4_LO && b < F0_MIN) ok = 1'b0;
        if (lead == LEAD4_HI && b > F4_MAX) ok = 1'b0;
        return ok;
    endfunction

    logic [7:0] r_pend [3];
    logic [7:0] n_pend [3];
    logic [1:0] r_cnt, n_cnt;
    logic [2:0] r_seq, n_seq;

    t_fresh                  fr;
    logic                    holding;
    logic                    cont_ok;
    logic                    complete;
    logic [2:0]              num;
    t_out_item [MAX_RESULTS-1:0] items;
    logic [7:0]              b;
    logic [2:0]              last_idx;

    assign b = i_item.byte_in;

    always_comb begin
        fr       = fresh(b, i_item.text_end);
        holding  = (r_cnt != 2'd0) && (r_seq >= 3'd2) && (r_seq <= 3'd4)
                   && ({1'b0, r_cnt} < r_seq);
        cont_ok  = ((b & CONT_MASK) == CONT_CODE)
                   && ((r_cnt != 2'd1) || second_ok(r_pend[0], b));
        complete = ({1'b0, r_cnt} + 3'd1) == r_seq;
        items    = '0;
        num      = 3'd0;
        n_pend   = r_pend;
        n_cnt    = r_cnt;
        n_seq    = r_seq;
        last_idx = 3'd0;

        if (holding && cont_ok) begin
            if (complete) begin
                if (r_seq == 3'd2 && r_pend[0] == LEAD2_LO && b <= C1_MAX) begin
                    items[0] = '{byte_out: CH_DOT, run_last: 1'b0, replaced: 1'b1};
                    num      = 3'd1;
                end else begin
                    for (int k = 0; k < 3; k++) begin
                        if (2'(k) < r_cnt) begin
                            items[k] = '{byte_out: r_pend[k], run_last: 1'b0,
                                         replaced: 1'b0};
                        end
                    end
                    items[r_cnt] = '{byte_out: b, run_last: 1'b0, replaced: 1'b0};
                    num          = {1'b0, r_cnt} + 3'd1;
                end
                n_cnt = 2'd0;
                n_seq = 3'd0;
            end else begin
                n_pend[r_cnt] = b;
                n_cnt         = r_cnt + 2'd1;
                if (i_item.text_end) begin
                    // Truncated at the end of the text: one dot per held byte.
                    for (int k = 0; k < 3; k++) begin
                        if (2'(k) < n_cnt) begin
                            items[k] = '{byte_out: CH_DOT, run_last: 1'b0,
                                         replaced: 1'b1};
                        end
                    end
                    num   = {1'b0, n_cnt};
                    n_cnt = 2'd0;
                    n_seq = 3'd0;
                end
            end
        end else begin
            // A broken sequence flushes its held bytes as dots first.
            if (holding) begin
                for (int k = 0; k < 3; k++) begin
                    if (2'(k) < r_cnt) begin
                        items[k] = '{byte_out: CH_DOT, run_last: 1'b0, replaced: 1'b1};
                    end
                end
                num = {1'b0, r_cnt};
            end
            if (fr.emit) begin
                items[num[1:0]] = '{byte_out: fr.value, run_last: 1'b0, replaced: fr.rep};
                num             = num + 3'd1;
            end
            if (fr.hold) begin
                n_pend[0] = b;
                n_cnt     = 2'd1;
                n_seq     = fr.need;
            end else begin
                n_cnt = 2'd0;
                n_seq = 3'd0;
            end
        end

        if (num != 3'd0) begin
            last_idx                       = num - 3'd1;
            items[last_idx[1:0]].run_last  = 1'b1;
        end
        o_result.num   = num;
        o_result.items = items;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_seq <= 3'd0;
        end else if (i_fire) begin
            r_cnt <= n_cnt;
            r_seq <= n_seq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_pend <= n_pend;
        end
    end

endmodule

/* hw/rtl/utf8vs_outq.sv */
// Output queue: takes up to four result items per cycle and presents one
// per cycle, when ready, on a valid/ready channel. Depends on utf8vs_pkg.
`timescale 1ns / 1ps

module utf8vs_outq import utf8vs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_dec_result i_result,
    output logic        o_room,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_data
);

    t_out_item       r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_AW:0]   r_cnt;
    logic [2:0]      push_n;
    logic            pop;

    assign push_n  = i_push ? i_result.num : 3'd0;
    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rp];
    // Room for a full group of results, judged on the registered count.
    assign o_room  = (r_cnt <= (Q_AW+1)'(Q_DEPTH - MAX_RESULTS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + Q_AW'(push_n);
            r_rp  <= r_rp + Q_AW'(pop);
            r_cnt <= r_cnt + (Q_AW+1)'(push_n) - (Q_AW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (3'(k) < push_n) begin
                r_mem[r_wp + Q_AW'(k)] <= i_result.items[k];
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (Q_AW+1)'(Q_DEPTH))
        else $error("output queue overflow");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_n == 3'd0 && !pop) |=> $stable(r_cnt))
        else $error("queue count moved without a transfer");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && i_result.num != 3'd0) |-> o_room)
        else $error("results pushed without room");

endmodule

/* hw/rtl/utf8_validating_sanitizer.sv */
// Results: a byte's result group is registered into the output queue at its transfer.
// Throughput: one input byte per cycle while the queue has room; the output queue drains one per cycle when ready.
// The decoder produces up to four items per byte; the queue gates input ready.
// Reset: synchronous, active low; clears pending sequence and queue pointers.
// Held sequence bytes and queue entries are not reset.
`timescale 1ns / 1ps

module utf8_validating_sanitizer import utf8vs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    // An input transfer happens when the input is valid and the queue can
    // take a full group of results. Each byte is decoded in the cycle of its
    // transfer against the registered pending state, and its results land in
    // the queue registers. Counted from reset, the results never outnumber the
    // bytes taken, so the queue stays shallow and input ready stays high while
    // the consumer keeps up.

    logic        fire;
    t_dec_result result;

    assign fire = i_in_valid && o_in_ready;

    utf8vs_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (i_in_data),
        .o_result (result)
    );

    utf8vs_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (fire),
        .i_result (result),
        .o_room   (o_in_ready),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_data   (o_out_data)
    );

endmodule
